// ----- src/nfc_response_frame_deframer_unit_defines.svh -----
// assertion macros shared by the deframer checker
`ifndef NFC_RESPONSE_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define NFC_RESPONSE_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// concurrent assertion on a given clock and active-low reset
`define NFCDFR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same, on the block clock and reset
`define NFCDFR_ASSERT(lbl, prop, msg) \
  `NFCDFR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- src/nfcdfr_pkg.sv -----
// types and constants of the response frame deframer
package nfcdfr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_HEADER = 4'd1,
    PH_EXT_MS = 4'd2,
    PH_EXT_LS = 4'd3,
    PH_EXT_CS = 4'd4,
    PH_TFI    = 4'd5,
    PH_CMD    = 4'd6,
    PH_BODY   = 4'd7,
    PH_DCS    = 4'd8,
    PH_POST   = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_ERRFRAME = 2'd2,
    ST_NOSPACE  = 2'd3
  } status_e;

  // configuration register indexes
  localparam logic [1:0] CFG_EXP_CMD  = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_FRAME_ID = 2'd2;

  localparam logic [7:0]  EXP_CMD_RST  = 8'd0;
  localparam logic [15:0] CAPACITY_RST = 16'hFFFF;
  localparam logic [7:0]  FRAME_ID_RST = 8'hD5;

  // frame constants
  localparam logic [7:0] PREAMBLE_BYTE = 8'h00;
  localparam logic [7:0] START_BYTE    = 8'hFF;
  localparam logic [7:0] EXT_MARK      = 8'hFF;
  localparam logic [7:0] ERR_TFI       = 8'h7F;
  localparam logic [7:0] ERR_CMD       = 8'h81;
  localparam logic [2:0] HDR_LEN_POS   = 3'd3;
  localparam logic [2:0] HDR_LCS_POS   = 3'd4;

  // result queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0]  exp_cmd;
    logic [15:0] capacity;
    logic [7:0]  frame_id;
  } cfg_t;

  // compact result: value is the data byte or the payload length
  typedef struct packed {
    logic        last;
    status_e     status;
    logic [15:0] value;
  } token_t;

endpackage

// ----- src/nfc_response_frame_deframer_unit.sv -----
// top level of the response frame deframer
// Takes one received byte per cycle: a byte is accepted when push is high and
// full is low, a new frame begins on a byte with frame_start_i set, and the
// parser updates its state in that same cycle. Payload bytes and the closing
// status of each frame go through a four-entry queue into one output register,
// so a result is registered in a queue slot and then in the output register.
// full rises only when the queue is full because results are not being popped;
// with pop held high the block runs at one byte per cycle indefinitely.
// Configuration writes are always ready and take effect on the next byte.
module nfc_response_frame_deframer_unit import nfcdfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_length_o,
  output logic        last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t   cfg_q;
  logic   accept;
  logic   res_valid;
  token_t res;
  logic   q_rd, q_nonempty, q_full;
  token_t q_data;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exp_cmd  <= EXP_CMD_RST;
      cfg_q.capacity <= CAPACITY_RST;
      cfg_q.frame_id <= FRAME_ID_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_EXP_CMD:  cfg_q.exp_cmd  <= cfg_data_i[7:0];
        CFG_CAPACITY: cfg_q.capacity <= cfg_data_i;
        CFG_FRAME_ID: cfg_q.frame_id <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  nfcdfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .rx_byte_i     (rx_byte_i),
    .frame_start_i (frame_start_i),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  nfcdfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (accept && res_valid),
    .wr_data_i  (res),
    .rd_i       (q_rd),
    .rd_data_o  (q_data),
    .nonempty_o (q_nonempty),
    .full_o     (q_full)
  );

  nfcdfr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_nonempty_i     (q_nonempty),
    .q_data_i         (q_data),
    .q_rd_o           (q_rd),
    .pop              (pop),
    .empty            (empty),
    .data_byte_o      (data_byte_o),
    .status_o         (status_o),
    .payload_length_o (payload_length_o),
    .last_o           (last_o)
  );

endmodule

// ----- src/nfcdfr_front.sv -----
// byte parser: walks the frame layout and produces result tokens
module nfcdfr_front import nfcdfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_start_i,
  output logic       res_valid_o,
  output token_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  header_count_q, header_count_d;
  logic        header_bad_q, header_bad_d;
  logic [7:0]  length_byte_q, length_byte_d;
  logic [7:0]  ext_high_q, ext_high_d;
  logic [7:0]  ext_low_q, ext_low_d;
  logic [15:0] payload_len_q, payload_len_d;
  logic [15:0] body_count_q, body_count_d;
  logic [7:0]  frame_id_q, frame_id_d;
  logic [7:0]  running_sum_q, running_sum_d;
  status_e     pending_q, pending_d;

  // a flagged byte restarts the header walk
  phase_e      ph;
  logic [2:0]  hc;
  logic        hb;
  logic [15:0] body_next;
  logic [7:0]  lcs_sum;
  logic [7:0]  ext_sum;
  logic        cmd_match;

  assign ph        = frame_start_i ? PH_HEADER : phase_q;
  assign hc        = frame_start_i ? 3'd0 : header_count_q;
  assign hb        = frame_start_i ? 1'b0 : header_bad_q;
  assign body_next = body_count_q + 16'd1;
  assign lcs_sum   = length_byte_q + rx_byte_i;
  assign ext_sum   = ext_high_q + ext_low_q + rx_byte_i;
  assign cmd_match = {1'b0, rx_byte_i} == ({1'b0, cfg_i.exp_cmd} + 9'd1);

  // next state
  always_comb begin
    phase_d        = ph;
    header_count_d = hc;
    header_bad_d   = hb;
    length_byte_d  = length_byte_q;
    ext_high_d     = ext_high_q;
    ext_low_d      = ext_low_q;
    payload_len_d  = payload_len_q;
    body_count_d   = body_count_q;
    frame_id_d     = frame_id_q;
    running_sum_d  = running_sum_q;
    pending_d      = pending_q;
    unique case (ph)
      PH_HEADER: begin
        if (hc < HDR_LEN_POS) begin
          if (rx_byte_i != ((hc == 3'd2) ? START_BYTE : PREAMBLE_BYTE)) header_bad_d = 1'b1;
          header_count_d = hc + 3'd1;
        end else if (hc == HDR_LEN_POS) begin
          length_byte_d  = rx_byte_i;
          header_count_d = HDR_LCS_POS;
        end else if (hb) begin
          phase_d = PH_IDLE;
        end else if (length_byte_q == EXT_MARK && rx_byte_i == EXT_MARK) begin
          phase_d = PH_EXT_MS;
        end else if (lcs_sum != 8'd0) begin
          phase_d = PH_IDLE;
        end else begin
          payload_len_d = (length_byte_q >= 8'd2) ? {8'd0, length_byte_q - 8'd2}
                                                  : {8'd0, length_byte_q};
          phase_d = PH_TFI;
        end
      end
      PH_EXT_MS: begin
        ext_high_d = rx_byte_i;
        phase_d    = PH_EXT_LS;
      end
      PH_EXT_LS: begin
        ext_low_d = rx_byte_i;
        phase_d   = PH_EXT_CS;
      end
      PH_EXT_CS: begin
        if (ext_sum != 8'd0) begin
          phase_d = PH_IDLE;
        end else begin
          payload_len_d = {ext_high_q, ext_low_q} - 16'd2;
          phase_d       = PH_TFI;
        end
      end
      PH_TFI: begin
        frame_id_d = rx_byte_i;
        phase_d    = PH_CMD;
      end
      PH_CMD: begin
        if (payload_len_q == 16'd1 && frame_id_q == ERR_TFI && rx_byte_i == ERR_CMD)
          pending_d = ST_ERRFRAME;
        else if (frame_id_q != cfg_i.frame_id || !cmd_match)
          pending_d = ST_INVALID;
        else if (payload_len_q > cfg_i.capacity)
          pending_d = ST_NOSPACE;
        else
          pending_d = ST_OK;
        running_sum_d = cfg_i.frame_id + rx_byte_i;
        body_count_d  = 16'd0;
        phase_d       = (payload_len_q == 16'd0) ? PH_DCS : PH_BODY;
      end
      PH_BODY: begin
        body_count_d = body_next;
        if (body_next == payload_len_q) phase_d = PH_DCS;
        if (pending_q == ST_OK) running_sum_d = running_sum_q + rx_byte_i;
      end
      PH_DCS: begin
        if (pending_q == ST_OK && (running_sum_q + rx_byte_i) != 8'd0)
          pending_d = ST_INVALID;
        phase_d = PH_POST;
      end
      PH_POST: phase_d = PH_IDLE;
      PH_IDLE: phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  // result token for this byte
  always_comb begin
    res_valid_o  = 1'b0;
    res_o.last   = 1'b1;
    res_o.status = ST_INVALID;
    res_o.value  = 16'd0;
    unique case (ph)
      PH_HEADER: begin
        if (hc == HDR_LCS_POS) begin
          if (hb) res_valid_o = 1'b1;
          else if (!(length_byte_q == EXT_MARK && rx_byte_i == EXT_MARK) && lcs_sum != 8'd0)
            res_valid_o = 1'b1;
        end
      end
      PH_EXT_CS: res_valid_o = (ext_sum != 8'd0);
      PH_BODY: begin
        if (pending_q == ST_OK) begin
          res_valid_o  = 1'b1;
          res_o.last   = 1'b0;
          res_o.status = ST_OK;
          res_o.value  = {8'd0, rx_byte_i};
        end
      end
      PH_POST: begin
        res_valid_o  = 1'b1;
        res_o.status = pending_q;
        res_o.value  = payload_len_q;
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      header_count_q <= 3'd0;
      header_bad_q   <= 1'b0;
      pending_q      <= ST_OK;
    end else if (accept_i) begin
      phase_q        <= phase_d;
      header_count_q <= header_count_d;
      header_bad_q   <= header_bad_d;
      pending_q      <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      length_byte_q <= length_byte_d;
      ext_high_q    <= ext_high_d;
      ext_low_q     <= ext_low_d;
      payload_len_q <= payload_len_d;
      body_count_q  <= body_count_d;
      frame_id_q    <= frame_id_d;
      running_sum_q <= running_sum_d;
    end
  end

endmodule

// ----- src/nfcdfr_queue.sv -----
// short token queue between parser and output stage
module nfcdfr_queue import nfcdfr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_i,
  input  token_t wr_data_i,
  input  logic   rd_i,
  output token_t rd_data_o,
  output logic   nonempty_o,
  output logic   full_o
);

  localparam logic [QAW:0] DEPTH_CNT = (QAW+1)'(QDEPTH);

  token_t         slots_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q;
  logic           do_rd;

  assign nonempty_o = (count_q != '0);
  assign full_o     = (count_q == DEPTH_CNT);
  assign do_rd      = rd_i && nonempty_o;
  assign rd_data_o  = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) slots_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) wr_ptr_q <= wr_ptr_q + QAW'(1);
      if (do_rd) rd_ptr_q <= rd_ptr_q + QAW'(1);
      if (wr_i && !do_rd) count_q <= count_q + (QAW+1)'(1);
      else if (!wr_i && do_rd) count_q <= count_q - (QAW+1)'(1);
    end
  end

endmodule

// ----- src/nfcdfr_back.sv -----
// output stage: holds one result and expands tokens to result fields
module nfcdfr_back import nfcdfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_nonempty_i,
  input  token_t      q_data_i,
  output logic        q_rd_o,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_length_o,
  output logic        last_o
);

  logic   valid_q;
  token_t tok_q;

  // refill when the held beat is gone or leaves this cycle
  assign q_rd_o = q_nonempty_i && (!valid_q || pop);
  assign empty  = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) tok_q <= q_data_i;
  end

  always_comb begin
    last_o           = tok_q.last;
    status_o         = tok_q.last ? tok_q.status : ST_OK;
    data_byte_o      = tok_q.last ? 8'd0 : tok_q.value[7:0];
    payload_length_o = (tok_q.last && tok_q.status == ST_OK) ? tok_q.value : 16'd0;
  end

endmodule

// ----- src/nfcdfr_checker.sv -----
// port-level checks of the deframer, bound to the top level
`include "nfc_response_frame_deframer_unit_defines.svh"

module nfcdfr_checker import nfcdfr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  data_byte_o,
  input logic [1:0]  status_o,
  input logic [15:0] payload_length_o,
  input logic        last_o
);

  // a waiting beat stays and holds its fields
  `NFCDFR_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(data_byte_o) && $stable(status_o) && $stable(payload_length_o) && $stable(last_o)), "result changed while waiting")

  `NFCDFR_ASSERT(a_data_clean, (!empty && !last_o) |-> (status_o == ST_OK && payload_length_o == 16'd0), "data beat carries status or length")

  `NFCDFR_ASSERT(a_status_byte, (!empty && last_o) |-> (data_byte_o == 8'd0), "status beat carries a data byte")

  `NFCDFR_ASSERT(a_len_ok_only, (!empty && last_o && status_o != ST_OK) |-> (payload_length_o == 16'd0), "length on a failed frame")

endmodule

bind nfc_response_frame_deframer_unit nfcdfr_checker u_checker (.*);
